// File: rtl/tww_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the tube warmth waveshaper.
// No dependencies; every other file but tww_checker imports this package.
package tww_pkg;

  // Fraction bits of all internal values and coefficients
  localparam int Q_FRAC          = 24;
  // Sign plus integer bits of a sample (Q3.20 at 24 bits)
  localparam int SAMPLE_INT_BITS = 4;
  // Width of the blocker pole register
  localparam int POLE_WIDTH      = 25;
  // Width of the configuration register index
  localparam int CFG_IDX_WIDTH   = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_POS_OFFSET   = 4'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_POS_LINEAR   = 4'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_POS_BIAS     = 4'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_NEG_OFFSET   = 4'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_NEG_LINEAR   = 4'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_NEG_BIAS     = 4'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OUT_GAIN     = 4'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BLOCKER_POLE = 4'd7;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_LIN,
    OP_ARG,
    OP_GAIN,
    OP_MED,
    OP_DIFF,
    OP_POLE,
    OP_OUT
  } dp_op_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIN,
    ST_WAIT_LIN,
    ST_ARG,
    ST_WAIT_ROOT,
    ST_GAIN,
    ST_WAIT_GAIN,
    ST_MED,
    ST_DIFF,
    ST_POLE,
    ST_WAIT_POLE,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic root_done;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/tube_warmth_waveshaper.sv
`timescale 1ns / 1ps
// Tube warmth waveshaper, top level: stream ports, configuration port,
// controller and datapath. Uses tww_pkg, tww_ctrl and tww_datapath.
//
// Square-root tube waveshaper followed by a one-pole DC blocker. Each input
// sample (signed Q3.20 at the default width) yields exactly one output
// sample, low-clamped at -1.0 and saturated at the format maximum; tlast is
// copied through. One sample is processed at a time, through the radix-4
// square-root unit and three passes through the shared multiplier. A
// finished sample waits in the output register while the next one is
// processed. The eight coefficients are to be written through the
// configuration port only while the block is idle; the block itself does
// not enforce this. Indexes beyond the list are ignored.
module tube_warmth_waveshaper #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 40
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [tww_pkg::CFG_IDX_WIDTH-1:0]      cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]                  cfg_data_i,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // sample_in
  input  logic                                   s_axis_tlast,  // block_end_in
  // output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,  // sample_out
  output logic                                   m_axis_tlast   // block_end_out
);
  import tww_pkg::*;

  localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  dp_cmd_t                 cmd;
  dp_status_t              status;
  logic [SAMPLE_WIDTH-1:0] out_sample;

  tww_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .cmd_o   (cmd),
    .status_i(status)
  );

  tww_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sample_o(out_sample),
    .out_last_o  (m_axis_tlast)
  );

  // Zero-pad the sample to whole bytes
  assign m_axis_tdata = TDW'(out_sample);

endmodule

// File: rtl/tww_mul.sv
`timescale 1ns / 1ps
// Sequential signed fractional multiplier: four half-width partial products,
// truncation toward zero by 24 bits, saturation to COEF_WIDTH. Uses tww_pkg.
module tww_mul #(
  parameter int COEF_WIDTH = 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COEF_WIDTH-1:0] a_i,
  input  logic signed [COEF_WIDTH-1:0] b_i,
  output logic                         done_o,
  output logic signed [COEF_WIDTH-1:0] res_o
);
  import tww_pkg::*;

  localparam int HW   = (COEF_WIDTH + 1) / 2;
  localparam int AW   = 2 * COEF_WIDTH;
  localparam int MAGW = AW - Q_FRAC;
  localparam logic signed [COEF_WIDTH-1:0] RES_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0] RES_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  logic                         busy_q, fin_q, neg_q;
  logic [1:0]                   step_q;
  logic [COEF_WIDTH-1:0]        ua_q, ub_q;
  logic [AW-1:0]                acc_q;
  logic signed [COEF_WIDTH-1:0] res_q;

  logic [COEF_WIDTH-1:0] ua_d, ub_d;
  logic [HW-1:0]         a_ch, b_ch;
  logic [2*HW-1:0]       pp;
  logic [AW-1:0]         pp_sh;
  logic [MAGW-1:0]       mag;
  logic                  over;
  logic signed [COEF_WIDTH-1:0] res_d;

  // Operand magnitudes
  always_comb begin
    ua_d = a_i[COEF_WIDTH-1] ? COEF_WIDTH'(-a_i) : COEF_WIDTH'(a_i);
    ub_d = b_i[COEF_WIDTH-1] ? COEF_WIDTH'(-b_i) : COEF_WIDTH'(b_i);
  end

  // Select the half-words of this step and align the partial product
  always_comb begin
    a_ch = step_q[1] ? HW'(ua_q[COEF_WIDTH-1:HW]) : ua_q[HW-1:0];
    b_ch = step_q[0] ? HW'(ub_q[COEF_WIDTH-1:HW]) : ub_q[HW-1:0];
    pp   = a_ch * b_ch;
    case (step_q)
      2'd0:    pp_sh = AW'(pp);
      2'd3:    pp_sh = AW'(pp) << (2 * HW);
      default: pp_sh = AW'(pp) << HW;
    endcase
  end

  // Drop the fraction and saturate the signed result
  always_comb begin
    mag  = acc_q[AW-1:Q_FRAC];
    over = |mag[MAGW-1:COEF_WIDTH-1];
    if (neg_q) begin
      res_d = over ? RES_MIN : -signed'(mag[COEF_WIDTH-1:0]);
    end else begin
      res_d = over ? RES_MAX : signed'(mag[COEF_WIDTH-1:0]);
    end
  end

  // Sequence: start, four accumulate steps, finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      step_q <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // Operands, accumulator and result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= ua_d;
      ub_q  <= ub_d;
      neg_q <= a_i[COEF_WIDTH-1] ^ b_i[COEF_WIDTH-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = fin_q;
  assign res_o  = res_q;

endmodule

// File: rtl/tww_sqrt.sv
`timescale 1ns / 1ps
// Restoring integer square root, two root bits per cycle:
// root = floor(sqrt(rad * 2^24)). Uses tww_pkg.
module tww_sqrt #(
  parameter int COEF_WIDTH = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COEF_WIDTH-1:0] rad_i,
  output logic                  done_o,
  output logic [2*((COEF_WIDTH+tww_pkg::Q_FRAC+3)/4)-1:0] root_o
);
  import tww_pkg::*;

  localparam int RW    = 2 * ((COEF_WIDTH + Q_FRAC + 3) / 4);
  localparam int RADW  = 2 * RW;
  localparam int REMW  = RW + 3;
  localparam int NSTEP = RW / 2;
  localparam int CNTW  = $clog2(NSTEP);
  localparam logic [CNTW-1:0] LAST = CNTW'(NSTEP - 1);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [RADW-1:0] rad_q;
  logic [REMW-1:0] rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;

  logic [REMW-1:0] rem1, trial1, rem2, trial2;
  logic [RW-1:0]   root1;

  // Two dependent restoring steps
  always_comb begin
    rem1   = {rem_q[REMW-3:0], rad_q[RADW-1:RADW-2]};
    trial1 = REMW'({root_q, 2'b01});
    if (rem1 >= trial1) begin
      rem1  = rem1 - trial1;
      root1 = {root_q[RW-2:0], 1'b1};
    end else begin
      root1 = {root_q[RW-2:0], 1'b0};
    end
    rem2   = {rem1[REMW-3:0], rad_q[RADW-3:RADW-4]};
    trial2 = REMW'({root1, 2'b01});
    if (rem2 >= trial2) begin
      rem_d  = rem2 - trial2;
      root_d = {root1[RW-2:0], 1'b1};
    end else begin
      rem_d  = rem2;
      root_d = {root1[RW-2:0], 1'b0};
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNTW'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Radicand shift line, remainder and partial root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= RADW'({rad_i, {Q_FRAC{1'b0}}});
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 4;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = busy_q && (cnt_q == LAST);
  assign root_o = root_q;

endmodule

// File: rtl/tww_ctrl.sv
`timescale 1ns / 1ps
// Controller of the waveshaper: sequences the datapath operations of one
// sample and waits on the multiplier, root unit and output slot. Uses tww_pkg.
module tww_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  output tww_pkg::dp_cmd_t    cmd_o,
  input  tww_pkg::dp_status_t status_i
);
  import tww_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_IDLE;
    ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        ready_o = 1'b1;
        if (valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_LIN;
        end
      end
      ST_LIN: begin
        cmd_o.op = OP_LIN;
        state_d  = ST_WAIT_LIN;
      end
      ST_WAIT_LIN: begin
        if (status_i.mul_done) state_d = ST_ARG;
      end
      ST_ARG: begin
        cmd_o.op = OP_ARG;
        state_d  = ST_WAIT_ROOT;
      end
      ST_WAIT_ROOT: begin
        if (status_i.root_done) state_d = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.op = OP_GAIN;
        state_d  = ST_WAIT_GAIN;
      end
      ST_WAIT_GAIN: begin
        if (status_i.mul_done) state_d = ST_MED;
      end
      ST_MED: begin
        cmd_o.op = OP_MED;
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = ST_POLE;
      end
      ST_POLE: begin
        cmd_o.op = OP_POLE;
        state_d  = ST_WAIT_POLE;
      end
      ST_WAIT_POLE: begin
        if (status_i.mul_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output slot is free
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/tww_datapath.sv
`timescale 1ns / 1ps
// Datapath of the waveshaper: configuration registers, shaping and DC
// blocker arithmetic, filter state and output register. Uses tww_pkg,
// tww_mul and tww_sqrt.
module tww_datapath #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 40
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tww_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]             cfg_data_i,
  input  logic [SAMPLE_WIDTH-1:0]           sample_i,
  input  logic                              last_i,
  input  tww_pkg::dp_cmd_t                  cmd_i,
  output tww_pkg::dp_status_t               status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]           out_sample_o,
  output logic                              out_last_o
);
  import tww_pkg::*;

  localparam int CW    = COEF_WIDTH;
  localparam int SH    = Q_FRAC - (SAMPLE_WIDTH - SAMPLE_INT_BITS);
  localparam int SHP   = (SH > 0) ? SH : 0;
  localparam int SHN   = (SH < 0) ? -SH : 0;
  localparam int YW    = CW + SHN;
  localparam int RW    = 2 * ((CW + Q_FRAC + 3) / 4);
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_ONE = CW'(64'sd1 <<< Q_FRAC);
  localparam logic [POLE_WIDTH-1:0] POLE_ONE = POLE_WIDTH'(64'd1 << Q_FRAC);
  localparam logic signed [YW-1:0] Y_MIN =
    YW'(-(64'sd1 <<< (SAMPLE_WIDTH - SAMPLE_INT_BITS)));
  localparam logic signed [YW-1:0] Y_MAX = YW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);

  // Saturate a widened sum back to the coefficient range
  function automatic logic signed [CW-1:0] sat(input logic signed [CW:0] v);
    logic signed [CW-1:0] r;
    if (v[CW] != v[CW-1]) begin
      r = v[CW] ? C_MIN : C_MAX;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // Sample format to Q.24
  function automatic logic signed [CW-1:0] to_q(input logic signed [SAMPLE_WIDTH-1:0] s);
    logic signed [CW-1:0] t;
    t = CW'(s);
    return (t <<< SHP) >>> SHN;
  endfunction

  // Configuration registers
  logic signed [CW-1:0]   pos_off_q, pos_lin_q, pos_bias_q;
  logic signed [CW-1:0]   neg_off_q, neg_lin_q, neg_bias_q, gain_q;
  logic [POLE_WIDTH-1:0]  pole_q;

  // Working and state registers
  logic signed [CW-1:0]           x_q, med_q, diff_q, last_shaped_q;
  logic                           neg_q, last_q, out_last_q, out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] last_out_q;
  logic [SAMPLE_WIDTH-1:0]        out_sample_q;

  // Unit connections
  logic                 mul_start, mul_done, root_start, root_done;
  logic signed [CW-1:0] mul_a, mul_b, prod;
  logic [CW-1:0]        rad;
  logic [RW-1:0]        root;

  logic signed [CW-1:0]           arg, med_d;
  logic signed [CW:0]             root_ext;
  logic signed [YW-1:0]           y_full;
  logic signed [SAMPLE_WIDTH-1:0] y;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_off_q  <= '0;
      pos_lin_q  <= '0;
      pos_bias_q <= '0;
      neg_off_q  <= '0;
      neg_lin_q  <= '0;
      neg_bias_q <= '0;
      gain_q     <= C_ONE;
      pole_q     <= POLE_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POS_OFFSET:   pos_off_q  <= cfg_data_i;
        REG_POS_LINEAR:   pos_lin_q  <= cfg_data_i;
        REG_POS_BIAS:     pos_bias_q <= cfg_data_i;
        REG_NEG_OFFSET:   neg_off_q  <= cfg_data_i;
        REG_NEG_LINEAR:   neg_lin_q  <= cfg_data_i;
        REG_NEG_BIAS:     neg_bias_q <= cfg_data_i;
        REG_OUT_GAIN:     gain_q     <= cfg_data_i;
        REG_BLOCKER_POLE: pole_q     <= cfg_data_i[POLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Radicand, widened root, shaped value and output conversion
  always_comb begin
    arg      = neg_q ? sat((CW+1)'(neg_off_q) - (CW+1)'(prod))
                     : sat((CW+1)'(pos_off_q) + (CW+1)'(prod));
    rad      = arg[CW-1] ? CW'(-arg) : CW'(arg);
    root_ext = signed'((CW+1)'(root));
    med_d    = neg_q ? sat(-(CW+1)'(prod)) : prod;
    y_full   = (YW'(prod) <<< SHN) >>> SHP;
    if (y_full < Y_MIN) begin
      y = SAMPLE_WIDTH'(Y_MIN);
    end else if (y_full > Y_MAX) begin
      y = SAMPLE_WIDTH'(Y_MAX);
    end else begin
      y = SAMPLE_WIDTH'(y_full);
    end
  end

  // Start the shared multiplier and the root unit
  always_comb begin
    mul_start  = 1'b0;
    root_start = 1'b0;
    mul_a      = x_q;
    mul_b      = '0;
    unique case (cmd_i.op)
      OP_LIN: begin
        mul_start = 1'b1;
        mul_b     = neg_q ? sat((CW+1)'(neg_lin_q) + (CW+1)'(x_q))
                          : sat((CW+1)'(pos_lin_q) - (CW+1)'(x_q));
      end
      OP_ARG: root_start = 1'b1;
      OP_GAIN: begin
        mul_start = 1'b1;
        mul_a     = neg_q ? sat(root_ext + (CW+1)'(neg_bias_q))
                          : sat(root_ext + (CW+1)'(pos_bias_q));
        mul_b     = gain_q;
      end
      OP_POLE: begin
        mul_start = 1'b1;
        mul_a     = sat((CW+1)'(diff_q) + (CW+1)'(to_q(last_out_q)));
        mul_b     = signed'(CW'(pole_q));
      end
      default: ;
    endcase
  end

  // Sample registers along the sequence
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        x_q    <= to_q(signed'(sample_i));
        neg_q  <= sample_i[SAMPLE_WIDTH-1];
        last_q <= last_i;
      end
      OP_MED:  med_q  <= med_d;
      OP_DIFF: diff_q <= sat((CW+1)'(med_q) - (CW+1)'(last_shaped_q));
      OP_OUT: begin
        out_sample_q <= y;
        out_last_q   <= last_q;
      end
      default: ;
    endcase
  end

  // Filter state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_shaped_q <= '0;
      last_out_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.op == OP_OUT) begin
        last_shaped_q <= med_q;
        last_out_q    <= y;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  tww_mul #(
    .COEF_WIDTH(CW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .res_o  (prod)
  );

  tww_sqrt #(
    .COEF_WIDTH(CW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(root_start),
    .rad_i  (rad),
    .done_o (root_done),
    .root_o (root)
  );

  assign status_o.mul_done  = mul_done;
  assign status_o.root_done = root_done;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_sample_o       = out_sample_q;
  assign out_last_o         = out_last_q;

endmodule

// File: rtl/tww_checker.sv
`timescale 1ns / 1ps
// Port-level checker of the tube warmth waveshaper and its bind to the top
// level. Watches the stream handshakes only; no package needed.
module tww_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic                              m_axis_tlast
);

  logic in_req;
  assign in_req = s_axis_tvalid && s_axis_tready;

  // One sample at a time: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> !s_axis_tready)
    else $error("input ready right after an accepted request");

  // A result cannot appear the cycle after a new sample is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_req && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result appeared too early");

  // A fresh result returns the block to accepting input
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result delivered but input not ready");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output changed");

endmodule

bind tube_warmth_waveshaper tww_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_tww_checker (.*);

// File: bench/tww_sample_checker.sv
`timescale 1ns / 1ps
// Output checker of the tube warmth waveshaper: mirrors the coefficient
// writes, predicts every shaped sample and compares it with the output stream.
// Depends on tww_pkg for register indexes and format constants.
module tww_sample_checker #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 40
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [tww_pkg::CFG_IDX_WIDTH-1:0]      cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]                  cfg_data_i,
  input  logic                                   s_tvalid_i,
  input  logic                                   s_tready_i,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata_i,   // sample_in
  input  logic                                   s_tlast_i,   // block_end_in
  input  logic                                   m_tvalid_i,
  input  logic                                   m_tready_i,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_tdata_i,   // sample_out
  input  logic                                   m_tlast_i,   // block_end_out
  output int                                     mismatches_o,
  output int                                     pending_o,
  output int                                     checked_o
);
  import tww_pkg::*;

  localparam int     SAMPLE_FRAC = SAMPLE_WIDTH - SAMPLE_INT_BITS;
  localparam int     Q_SHIFT     = Q_FRAC - SAMPLE_FRAC;
  localparam longint COEF_MAX    = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
  localparam longint COEF_MIN    = -COEF_MAX - 1;
  localparam longint OUT_MIN     = -(longint'(1) <<< SAMPLE_FRAC);
  localparam longint OUT_MAX     = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam logic [127:0] MAG_LIMIT = 128'd1 << (COEF_WIDTH - 1);

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    block_end;
  } shaped_sample_t;

  logic [COEF_WIDTH-1:0] coef_regs [0:REG_BLOCKER_POLE];
  longint                prev_shaped;
  longint                last_output;
  shaped_sample_t        expected_q [$];
  int                    mismatch_count;
  int                    checked_count;

  function automatic longint sat_coef(longint v);
    if (v > COEF_MAX) return COEF_MAX;
    if (v < COEF_MIN) return COEF_MIN;
    return v;
  endfunction

  // trunc(a*b / 2^Q_FRAC), saturated to the coefficient range
  function automatic longint q_mul(longint a, longint b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] prod;
    logic         neg;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = ({64'd0, ua} * {64'd0, ub}) >> Q_FRAC;
    if (neg) return (prod >= MAG_LIMIT) ? COEF_MIN : -longint'(prod[63:0]);
    return (prod >= MAG_LIMIT) ? COEF_MAX : longint'(prod[63:0]);
  endfunction

  // floor(sqrt(mag * 2^Q_FRAC)), bit by bit from the top
  function automatic longint q_root(logic [63:0] mag);
    logic [127:0] scaled;
    logic [63:0]  root;
    logic [63:0]  trial;
    int           b;
    scaled = {64'd0, mag} << Q_FRAC;
    root   = '0;
    for (b = 47; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if ({64'd0, trial} * {64'd0, trial} <= scaled) root = trial;
    end
    return longint'(root);
  endfunction

  function automatic longint to_q(longint s);
    if (Q_SHIFT >= 0) return s * (longint'(1) <<< Q_SHIFT);
    return s >>> (-Q_SHIFT);
  endfunction

  function automatic longint from_q(longint v);
    if (Q_SHIFT >= 0) return v >>> Q_SHIFT;
    return v * (longint'(1) <<< (-Q_SHIFT));
  endfunction

  function automatic longint coef_of(logic [COEF_WIDTH-1:0] r);
    return longint'($signed(r));
  endfunction

  // square-root tube curve, separate coefficient sets per polarity
  function automatic longint tube_curve(longint x);
    longint arg;
    longint root_sum;
    longint prod;
    if (x >= 0) begin
      arg = sat_coef(coef_of(coef_regs[REG_POS_OFFSET]) +
                     q_mul(x, sat_coef(coef_of(coef_regs[REG_POS_LINEAR]) - x)));
      root_sum = sat_coef(q_root((arg < 0) ? -arg : arg) +
                          coef_of(coef_regs[REG_POS_BIAS]));
      return q_mul(root_sum, coef_of(coef_regs[REG_OUT_GAIN]));
    end
    arg = sat_coef(coef_of(coef_regs[REG_NEG_OFFSET]) -
                   q_mul(x, sat_coef(coef_of(coef_regs[REG_NEG_LINEAR]) + x)));
    root_sum = sat_coef(q_root((arg < 0) ? -arg : arg) +
                        coef_of(coef_regs[REG_NEG_BIAS]));
    prod = q_mul(root_sum, coef_of(coef_regs[REG_OUT_GAIN]));
    return sat_coef(-prod);
  endfunction

  // shape, then DC-block against the previous sample; advances the history
  function automatic shaped_sample_t shape_and_block(logic [SAMPLE_WIDTH-1:0] raw,
                                                     logic block_end);
    longint         med;
    longint         acc;
    longint         y;
    shaped_sample_t res;
    med = tube_curve(to_q(longint'($signed(raw))));
    acc = sat_coef(sat_coef(med - prev_shaped) + to_q(last_output));
    y   = from_q(q_mul(acc, longint'(coef_regs[REG_BLOCKER_POLE][POLE_WIDTH-1:0])));
    if (y < OUT_MIN) y = OUT_MIN;
    if (y > OUT_MAX) y = OUT_MAX;
    prev_shaped   = med;
    last_output   = y;
    res.sample    = y[SAMPLE_WIDTH-1:0];
    res.block_end = block_end;
    return res;
  endfunction

  // watch config, input and output channels on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    shaped_sample_t want;
    if (!rst_ni) begin
      foreach (coef_regs[i]) coef_regs[i] = '0;
      coef_regs[REG_OUT_GAIN]     = COEF_WIDTH'(1) << Q_FRAC;
      coef_regs[REG_BLOCKER_POLE] = COEF_WIDTH'(1) << Q_FRAC;
      prev_shaped    = 0;
      last_output    = 0;
      mismatch_count = 0;
      checked_count  = 0;
      expected_q.delete();
      mismatches_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
    end else begin
      // compare an accepted output against the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        if (expected_q.size() == 0) begin
          $error("output sample %0d with no request pending",
                 $signed(m_tdata_i[SAMPLE_WIDTH-1:0]));
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (m_tdata_i[SAMPLE_WIDTH-1:0] !== want.sample) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   $signed(want.sample), $signed(m_tdata_i[SAMPLE_WIDTH-1:0]));
            mismatch_count++;
          end
          if (m_tlast_i !== want.block_end) begin
            $error("block_end_out mismatch: expected %0d, actual %0d",
                   want.block_end, m_tlast_i);
            mismatch_count++;
          end
          checked_count++;
        end
      end
      // predict each accepted request
      if (s_tvalid_i && s_tready_i)
        expected_q.push_back(shape_and_block(s_tdata_i[SAMPLE_WIDTH-1:0], s_tlast_i));
      // mirror coefficient writes, drop unused indexes
      if (cfg_we_i && cfg_idx_i <= REG_BLOCKER_POLE) begin
        if (cfg_idx_i == REG_BLOCKER_POLE)
          coef_regs[cfg_idx_i] = COEF_WIDTH'(cfg_data_i[POLE_WIDTH-1:0]);
        else
          coef_regs[cfg_idx_i] = cfg_data_i;
      end
      mismatches_o <= mismatch_count;
      pending_o    <= expected_q.size();
      checked_o    <= checked_count;
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Top of the waveshaper bench: clock, reset, coefficient settings, sample
// stimulus with random gaps and output back-pressure, and the verdict.
// Depends on tww_pkg, tube_warmth_waveshaper and tww_sample_checker.
module tb;
  import tww_pkg::*;

  localparam int     SAMPLE_WIDTH      = 24;
  localparam int     COEF_WIDTH        = 40;
  localparam int     DATA_WIDTH        = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int     RESET_CYCLES      = 5;
  localparam int     SINK_HOLD_CYCLES  = 400;
  localparam int     TAIL_CYCLES       = 60;
  localparam int     CYCLE_LIMIT       = 1_000_000;
  localparam longint SAMPLE_ONE        = longint'(1) <<< (SAMPLE_WIDTH - SAMPLE_INT_BITS);
  localparam longint SAMPLE_MAX        = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint SAMPLE_MIN        = -SAMPLE_MAX - 1;
  localparam longint COEF_MAX          = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
  localparam longint COEF_MIN          = -COEF_MAX - 1;
  localparam longint UNITY             = longint'(1) <<< Q_FRAC;
  localparam int     NUM_PHASES        = 9;

  typedef enum int {
    SET_TYPICAL,
    SET_ALL_MAX,
    SET_SAT_NEG,
    SET_ALL_MIN,
    SET_FULL_RANDOM,
    SET_HOT_POLE
  } setting_e;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_IDX_WIDTH-1:0]     cfg_idx_i;
  logic [COEF_WIDTH-1:0]        cfg_data_i;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [DATA_WIDTH-1:0]        s_axis_tdata;   // sample_in
  logic                         s_axis_tlast;   // block_end_in
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [DATA_WIDTH-1:0]        m_axis_tdata;   // sample_out
  logic                         m_axis_tlast;   // block_end_out

  int mismatches;
  int pending;
  int checked;
  int cycle_count     = 0;
  int settings_loaded = 0;
  int block_ends_sent = 0;
  bit quiet           = 1'b0;
  bit hold_sink       = 1'b0;

  tube_warmth_waveshaper #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  tww_sample_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // end the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still pending", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    int unsigned r;
    longint      v;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0:       v = SAMPLE_MAX;
        1:       v = SAMPLE_MIN;
        2:       v = 0;
        3:       v = 1;
        default: v = -1;
      endcase
    end else if (r < 45) begin
      v = longint'($urandom_range(0, 2 * SAMPLE_ONE)) - SAMPLE_ONE;
    end else begin
      v = longint'($urandom());
    end
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic longint rand_coef(longint span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // wait at clock edges until every predicted sample has come out
  task automatic drain();
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [COEF_WIDTH-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // program all eight coefficients, plus one write to an unused index
  task automatic load_setting(setting_e kind);
    longint vals [0:REG_BLOCKER_POLE];
    int     i;
    case (kind)
      SET_ALL_MAX: begin
        foreach (vals[k]) vals[k] = COEF_MAX;
        vals[REG_BLOCKER_POLE] = UNITY;
      end
      SET_SAT_NEG: begin
        vals[REG_POS_OFFSET] = COEF_MIN;
        vals[REG_POS_LINEAR] = COEF_MIN;
        vals[REG_POS_BIAS]   = COEF_MAX;
        vals[REG_NEG_OFFSET] = COEF_MIN;
        vals[REG_NEG_LINEAR] = COEF_MIN;
        vals[REG_NEG_BIAS]   = COEF_MAX;
        vals[REG_OUT_GAIN]   = COEF_MIN;
        vals[REG_BLOCKER_POLE] = UNITY;
      end
      SET_ALL_MIN: begin
        foreach (vals[k]) vals[k] = COEF_MIN;
        vals[REG_BLOCKER_POLE] = 0;
      end
      SET_FULL_RANDOM: begin
        foreach (vals[k]) vals[k] = {$urandom(), $urandom()};
        vals[REG_BLOCKER_POLE] = $urandom_range(0, UNITY);
      end
      default: begin
        vals[REG_POS_OFFSET] = rand_coef(longint'(1) <<< 26);
        vals[REG_POS_LINEAR] = rand_coef(longint'(1) <<< 26);
        vals[REG_POS_BIAS]   = rand_coef(UNITY);
        vals[REG_NEG_OFFSET] = rand_coef(longint'(1) <<< 26);
        vals[REG_NEG_LINEAR] = rand_coef(longint'(1) <<< 26);
        vals[REG_NEG_BIAS]   = rand_coef(UNITY);
        vals[REG_OUT_GAIN]   = $urandom_range(UNITY / 2, 2 * UNITY);
        vals[REG_BLOCKER_POLE] = UNITY - $urandom_range(0, UNITY / 16);
        if (kind == SET_HOT_POLE) begin
          vals[REG_OUT_GAIN]     = $urandom_range(UNITY / 4, UNITY);
          vals[REG_BLOCKER_POLE] = $urandom_range(UNITY + 1, (1 << POLE_WIDTH) - 1);
        end
      end
    endcase
    for (i = 0; i <= REG_BLOCKER_POLE; i++)
      write_reg(CFG_IDX_WIDTH'(i), vals[i][COEF_WIDTH-1:0]);
    write_reg(REG_BLOCKER_POLE + CFG_IDX_WIDTH'($urandom_range(1, 8)),
              {$urandom(), $urandom()});
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  // offer one sample after a random gap and hold it until accepted
  task automatic send_sample(logic [SAMPLE_WIDTH-1:0] value, logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_WIDTH'(value);
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (last) block_ends_sent++;
  endtask

  // output side: ready bursts, random stalls, one long hold-off on request
  initial begin : sink_side
    int run_len;
    int stall_len;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
        hold_sink = 1'b0;
      end else begin
        run_len = $urandom_range(1, 40);
        m_axis_tready <= 1'b1;
        repeat (run_len) @(posedge clk_i);
        stall_len = idle_len();
        if (stall_len > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall_len) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    logic [SAMPLE_WIDTH-1:0] corner_samples [12];
    setting_e                plan_kind [NUM_PHASES];
    int                      plan_items [NUM_PHASES];
    int                      p;
    int                      n;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_POS_OFFSET;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner samples under the reset coefficients (unity gain and pole)
    corner_samples = '{SAMPLE_WIDTH'(0), SAMPLE_WIDTH'(1), SAMPLE_WIDTH'(-1),
                       SAMPLE_WIDTH'(SAMPLE_MAX), SAMPLE_WIDTH'(SAMPLE_MIN),
                       SAMPLE_WIDTH'(SAMPLE_ONE), SAMPLE_WIDTH'(-SAMPLE_ONE),
                       SAMPLE_WIDTH'(-SAMPLE_ONE - 1), SAMPLE_WIDTH'(2 * SAMPLE_ONE),
                       SAMPLE_WIDTH'(-4 * SAMPLE_ONE), 24'h555555, 24'haaaaaa};
    foreach (corner_samples[i]) send_sample(corner_samples[i], (i % 3) == 2);
    s_axis_tvalid <= 1'b0;
    drain();

    plan_kind  = '{SET_TYPICAL, SET_ALL_MAX, SET_SAT_NEG, SET_ALL_MIN, SET_FULL_RANDOM,
                   SET_HOT_POLE, SET_TYPICAL, SET_TYPICAL, SET_FULL_RANDOM};
    plan_items = '{150, 60, 60, 40, 150, 120, 150, 150, 120};

    for (p = 0; p < NUM_PHASES; p++) begin
      load_setting(plan_kind[p]);
      quiet = (p == 6);
      // back-pressure phase: the sink holds off while samples keep coming
      if (p == 7) hold_sink = 1'b1;
      for (n = 0; n < plan_items[p]; n++) begin
        send_sample(pick_sample(), $urandom_range(0, 7) == 0);
        // pause the source mid-phase until the block has emptied
        if (p == 7 && n == plan_items[p] / 2) begin
          s_axis_tvalid <= 1'b0;
          drain();
        end
      end
      s_axis_tvalid <= 1'b0;
      drain();
    end

    quiet = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Shaped %0d samples (%0d block ends) under %0d coefficient settings,",
             checked, block_ends_sent, settings_loaded);
    $display("with source gaps, sink stalls and one long sink hold-off; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
